>>> design/rlps_pkg.sv
package rlps_pkg;

    localparam int CMD_W    = 2;
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;
    localparam int PULSE_W  = 16;
    localparam int TICK_W   = 20;
    localparam int BITS_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TICK_W;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;

    // command codes on the input tuser
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LATCH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ONE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ZERO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd3;

    localparam logic [PULSE_W-1:0] RST_HIGH_ONE  = 16'd70;
    localparam logic [PULSE_W-1:0] RST_HIGH_ZERO = 16'd35;
    localparam logic [PULSE_W-1:0] RST_LOW_BIT   = 16'd60;
    localparam logic [TICK_W-1:0]  RST_LATCH     = 20'd600;

    localparam logic [BITS_W-1:0] PIXEL_BITS = 5'd24;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_PIXEL,
        KIND_LATCH
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [PIXEL_W-1:0] pixel;  // green, red, blue from msb down
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic ignored;
    } result_t;

    // a zero time register behaves as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        logic [TICK_W-1:0] r;
        r = (v == '0) ? {{(TICK_W-1){1'b0}}, 1'b1} : v;
        return r;
    endfunction

endpackage

>>> design/rlps_front.sv
module rlps_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rlps_pkg::CMD_W-1:0]   s_tuser,
    input  logic [rlps_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                         queue_full,
    output logic                         push,
    output rlps_pkg::item_t              push_item
);
    import rlps_pkg::*;

    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    assign red   = s_tdata[CHAN_W-1:0];
    assign green = s_tdata[2*CHAN_W-1:CHAN_W];
    assign blue  = s_tdata[3*CHAN_W-1:2*CHAN_W];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        // unused code 3 is a plain tick
        case (s_tuser)
            CMD_PIXEL: push_item.kind = KIND_PIXEL;
            CMD_LATCH: push_item.kind = KIND_LATCH;
            default:   push_item.kind = KIND_TICK;
        endcase
        push_item.pixel = {green, red, blue};
    end

endmodule

>>> design/rlps_queue.sv
module rlps_queue #(
    parameter int DEPTH = rlps_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rlps_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output rlps_pkg::item_t head_item
);
    import rlps_pkg::*;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    item_t              store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/rlps_back.sv
module rlps_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rlps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rlps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            not_empty,
    input  rlps_pkg::item_t                 head_item,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output rlps_pkg::result_t               result
);
    import rlps_pkg::*;

    logic [PULSE_W-1:0] high_one_reg;
    logic [PULSE_W-1:0] high_zero_reg;
    logic [PULSE_W-1:0] low_bit_reg;
    logic [TICK_W-1:0]  latch_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_next;
    logic [PIXEL_W-1:0] shift_reg;
    logic [PIXEL_W-1:0] shift_next;
    logic [BITS_W-1:0]  bits_reg;
    logic [BITS_W-1:0]  bits_next;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            out_next;

    phase_t             ph_start;
    logic [TICK_W-1:0]  tick_dec;
    logic [BITS_W-1:0]  bits_dec;
    logic [PIXEL_W-1:0] shift_adv;
    logic               is_cmd;

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;
    assign pop      = not_empty && (!out_valid_reg || m_tready);

    always_comb
    begin
        ph_start   = phase_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        out_next   = out_reg;
        tick_dec   = '0;
        bits_dec   = '0;
        shift_adv  = '0;
        is_cmd     = (head_item.kind == KIND_PIXEL) || (head_item.kind == KIND_LATCH);
        out_next.ignored = 1'b0;

        // command handling for this tick
        if (is_cmd && phase_reg != PH_IDLE)
        begin
            out_next.ignored = 1'b1;
        end
        else if (head_item.kind == KIND_PIXEL)
        begin
            shift_next = head_item.pixel;
            bits_next  = PIXEL_BITS;
            ph_start   = PH_HIGH;
            tick_next  = head_item.pixel[PIXEL_W-1] ? at_least_one(TICK_W'(high_one_reg))
                                                    : at_least_one(TICK_W'(high_zero_reg));
        end
        else if (head_item.kind == KIND_LATCH)
        begin
            ph_start  = PH_LATCH;
            tick_next = at_least_one(latch_reg);
        end

        out_next.line_level = (ph_start == PH_HIGH);
        out_next.busy_res   = (ph_start != PH_IDLE);
        phase_next          = ph_start;

        // advance the waveform by one tick
        if (ph_start != PH_IDLE)
        begin
            tick_dec = (tick_next != '0) ? tick_next - 1'b1 : tick_next;
            tick_next = tick_dec;
            if (tick_dec == '0)
            begin
                case (ph_start)
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        tick_next  = at_least_one(TICK_W'(low_bit_reg));
                    end
                    PH_LOW:
                    begin
                        shift_adv  = {shift_next[PIXEL_W-2:0], 1'b0};
                        bits_dec   = (bits_next != '0) ? bits_next - 1'b1 : bits_next;
                        shift_next = shift_adv;
                        bits_next  = bits_dec;
                        if (bits_dec == '0)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                            tick_next  = shift_adv[PIXEL_W-1]
                                ? at_least_one(TICK_W'(high_one_reg))
                                : at_least_one(TICK_W'(high_zero_reg));
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            shift_reg     <= '0;
            bits_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                shift_reg <= shift_next;
                bits_reg  <= bits_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_one_reg  <= RST_HIGH_ONE;
            high_zero_reg <= RST_HIGH_ZERO;
            low_bit_reg   <= RST_LOW_BIT;
            latch_reg     <= RST_LATCH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HIGH_ONE:  high_one_reg  <= cfg_data[PULSE_W-1:0];
                CFG_HIGH_ZERO: high_zero_reg <= cfg_data[PULSE_W-1:0];
                CFG_LOW_BIT:   low_bit_reg   <= cfg_data[PULSE_W-1:0];
                CFG_LATCH:     latch_reg     <= cfg_data[TICK_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

>>> design/rgb_led_pulse_width_serializer_unit.sv
// single-wire rgb led serializer
//
// every input word is one tick of the led line. s_tuser carries the command
// (plain tick, start pixel, start latch gap), s_tdata the colour. a pixel goes
// out green, red, blue, msb first; each bit is a high pulse of the one-time or
// zero-time followed by the low time. a latch gap holds the line low.
// commands that arrive while a pixel or latch is running are dropped and
// flagged in the result word.
// every input word gives exactly one result word on m_tdata, in order.
// throughput is one word per cycle while m_tready stays high; the tick state
// machine in the back end updates once per word. with the queue empty, an
// accepted word is written to the queue register and its result to the output
// register, and then m_tvalid rises with the result word.
// a stalled m_tready holds the output word; the queue between front and back
// keeps accepting until it fills, then s_tready drops.
// reset puts the line idle, empties the queue and loads the default times (70, 35, 60, 600
// ticks). timing registers are written through cfg_we, cfg_index, cfg_data. the user must
// write them only while the line is idle (not enforced); an unknown index is ignored.
module rgb_led_pulse_width_serializer_unit #(
    parameter int QUEUE_DEPTH = rlps_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rlps_pkg::IN_DATA_W-1:0]   s_tdata,  // red, green, blue, zero pad
    input  logic [rlps_pkg::CMD_W-1:0]       s_tuser,  // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rlps_pkg::OUT_DATA_W-1:0]  m_tdata,  // line_level, busy_res, ignored, zero pad
    input  logic                             cfg_we,
    input  logic [rlps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rlps_pkg::*;

    logic    push;
    item_t   push_item;
    logic    queue_full;
    logic    pop;
    logic    not_empty;
    item_t   head_item;
    result_t result;

    rlps_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    rlps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_item (head_item)
    );

    rlps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .not_empty (not_empty),
        .head_item (head_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {{(OUT_DATA_W-3){1'b0}}, result.ignored, result.busy_res, result.line_level};

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import rlps_pkg::*;

    // code 3 is not a command; the line treats it as a plain tick
    localparam logic [CMD_W-1:0]      CMD_SPARE    = 2'd3;
    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] blue;
    } tick_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [CMD_W-1:0]      s_tuser   = CMD_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // timing registers and line state as the block should hold them
    logic [PULSE_W-1:0] t_high_one;
    logic [PULSE_W-1:0] t_high_zero;
    logic [PULSE_W-1:0] t_low;
    logic [TICK_W-1:0]  t_latch;
    phase_t             lane_phase;
    logic [PIXEL_W-1:0] lane_bits;
    logic [BITS_W-1:0]  lane_bits_left;
    logic [TICK_W-1:0]  lane_ticks;

    tick_word_t tick_backlog[$];
    result_t    line_forecast[$];
    tick_word_t word_on_bus;
    result_t    due;
    int         words_queued;
    int         words_taken;
    int         words_seen;
    int         fail_count;
    int         burst_left;
    int         gap_left;
    int         stall_mode;
    int         stall_left;
    int         beat;

    rgb_led_pulse_width_serializer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // red, green, blue, zero pad
        .s_tuser   (s_tuser),   // command
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // line_level, busy_res, ignored, zero pad
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [TICK_W-1:0] one_if_zero(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // high time of the bit now at the top of the shift register
    function automatic logic [TICK_W-1:0] pulse_ticks();
        if (lane_bits[PIXEL_W-1])
            return one_if_zero(TICK_W'(t_high_one));
        return one_if_zero(TICK_W'(t_high_zero));
    endfunction

    // one tick of the led line: returns the word the block must give for it
    function automatic result_t advance_line(input tick_word_t w);
        result_t r;
        r.ignored = 1'b0;
        if (w.cmd == CMD_PIXEL || w.cmd == CMD_LATCH)
        begin
            if (lane_phase != PH_IDLE)
                r.ignored = 1'b1;
            else if (w.cmd == CMD_PIXEL)
            begin
                lane_bits      = {w.green, w.red, w.blue};
                lane_bits_left = PIXEL_BITS;
                lane_phase     = PH_HIGH;
                lane_ticks     = pulse_ticks();
            end
            else
            begin
                lane_phase = PH_LATCH;
                lane_ticks = one_if_zero(t_latch);
            end
        end
        r.line_level = (lane_phase == PH_HIGH);
        r.busy_res   = (lane_phase != PH_IDLE);
        if (lane_phase != PH_IDLE)
        begin
            if (lane_ticks != '0)
                lane_ticks = lane_ticks - 1'b1;
            if (lane_ticks == '0)
            begin
                case (lane_phase)
                    PH_HIGH:
                    begin
                        lane_phase = PH_LOW;
                        lane_ticks = one_if_zero(TICK_W'(t_low));
                    end
                    PH_LOW:
                    begin
                        lane_bits = lane_bits << 1;
                        if (lane_bits_left != '0)
                            lane_bits_left = lane_bits_left - 1'b1;
                        if (lane_bits_left == '0)
                            lane_phase = PH_IDLE;
                        else
                        begin
                            lane_phase = PH_HIGH;
                            lane_ticks = pulse_ticks();
                        end
                    end
                    default:
                        lane_phase = PH_IDLE;
                endcase
            end
        end
        return r;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < 40)
            $display("%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [CHAN_W-1:0] random_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic push_word(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] blue);
        tick_word_t w;
        w.cmd   = cmd;
        w.green = green;
        w.red   = red;
        w.blue  = blue;
        tick_backlog.push_back(w);
        words_queued++;
    endtask

    // plain ticks with junk colour, now and then the unused code
    task automatic push_filler(input int n);
        repeat (n)
            push_word(($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_TICK,
                      random_chan(), random_chan(), random_chan());
    endtask

    // sender holds off until every word is through and its result checked
    task automatic wait_drained();
        while (words_taken != words_queued || line_forecast.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic finish_activity();
        wait_drained();
        while (lane_phase != PH_IDLE)
        begin
            push_filler(int'(lane_ticks));
            wait_drained();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_HIGH_ONE:  t_high_one  = val[PULSE_W-1:0];
            CFG_HIGH_ZERO: t_high_zero = val[PULSE_W-1:0];
            CFG_LOW_BIT:   t_low       = val[PULSE_W-1:0];
            CFG_LATCH:     t_latch     = val[TICK_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic program_times(input logic [CFG_DATA_W-1:0] one, input logic [CFG_DATA_W-1:0] zero,
                                 input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] latch);
        write_reg(CFG_HIGH_ONE, one);
        write_reg(CFG_HIGH_ZERO, zero);
        write_reg(CFG_LOW_BIT, low);
        write_reg(CFG_LATCH, latch);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // sender: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= CMD_TICK;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                line_forecast.push_back(advance_line(word_on_bus));
                words_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (tick_backlog.size() > 0)
                begin
                    word_on_bus = tick_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - PIXEL_W){1'b0}},
                                 word_on_bus.blue, word_on_bus.green, word_on_bus.red};
                    s_tuser  <= word_on_bus.cmd;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each result word, stalls in stretches of changing shape
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
            beat       = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (line_forecast.size() == 0)
                    note_failure($sformatf("result word %0d with none expected", words_seen));
                else
                begin
                    due = line_forecast.pop_front();
                    if (m_tdata[0] !== due.line_level)
                        note_failure($sformatf("word %0d line_level %b, expected %b",
                                               words_seen, m_tdata[0], due.line_level));
                    if (m_tdata[1] !== due.busy_res)
                        note_failure($sformatf("word %0d busy_res %b, expected %b",
                                               words_seen, m_tdata[1], due.busy_res));
                    if (m_tdata[2] !== due.ignored)
                        note_failure($sformatf("word %0d ignored %b, expected %b",
                                               words_seen, m_tdata[2], due.ignored));
                end
                words_seen++;
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 300);
            end
            else
                stall_left--;
            beat++;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= (beat % 5 != 0);
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    initial
    begin
        int idx;
        int pick;
        logic [CMD_W-1:0] cmd;

        t_high_one     = RST_HIGH_ONE;
        t_high_zero    = RST_HIGH_ZERO;
        t_low          = RST_LOW_BIT;
        t_latch        = RST_LATCH;
        lane_phase     = PH_IDLE;
        lane_bits      = '0;
        lane_bits_left = '0;
        lane_ticks     = '0;
        words_queued   = 0;
        words_taken    = 0;
        words_seen     = 0;
        fail_count     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset latch time, commands dropped while the latch gap runs
        push_word(CMD_LATCH, 8'h80, 8'h01, 8'hFE);
        push_filler(5);
        push_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        push_word(CMD_LATCH, 8'h00, 8'h00, 8'h00);
        push_word(CMD_SPARE, 8'hFF, 8'h00, 8'hFF);
        finish_activity();

        // zero registers act as one tick
        program_times('0, '0, '0, '0);
        push_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        finish_activity();
        push_word(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        push_word(CMD_LATCH, 8'hFF, 8'hFF, 8'hFF);
        finish_activity();
        // one-tick latch, then a pixel on the very next word
        push_word(CMD_LATCH, 8'h00, 8'h00, 8'h00);
        push_word(CMD_PIXEL, 8'h55, 8'hAA, 8'hC3);
        finish_activity();

        program_times(1, 1, 1, 1);
        push_word(CMD_PIXEL, 8'h0F, 8'hF0, 8'h3C);
        push_word(CMD_LATCH, 8'h00, 8'h00, 8'h00);
        finish_activity();
        push_word(CMD_LATCH, 8'h00, 8'h00, 8'h00);
        push_word(CMD_LATCH, 8'h00, 8'h00, 8'h00);
        finish_activity();

        // one-time with data above 16 bits masked off, unknown indexes
        program_times(CFG_DATA_W'(20'hF0003), 1, 1, CFG_ALL_ONES);
        for (idx = int'(CFG_LATCH) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        push_word(CMD_PIXEL, 8'h00, 8'h00, 8'h01);
        finish_activity();

        // long zero-time
        program_times(1, CFG_DATA_W'(16'h0040), 1, 2);
        push_word(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFE);
        finish_activity();

        // widest low time, latch gaps only
        program_times(1, 1, CFG_DATA_W'(16'hFFFF), 2);
        push_word(CMD_LATCH, 8'hFF, 8'h00, 8'hFF);
        push_word(CMD_LATCH, 8'h00, 8'hFF, 8'h00);
        push_word(CMD_LATCH, 8'h00, 8'h00, 8'h00);
        finish_activity();

        // random words over several short time settings
        repeat (4)
        begin
            program_times(CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 6)),
                          CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 40)));
            repeat (120)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 66)
                    cmd = CMD_TICK;
                else if (pick < 74)
                    cmd = CMD_SPARE;
                else if (pick < 88)
                    cmd = CMD_PIXEL;
                else
                    cmd = CMD_LATCH;
                push_word(cmd, random_chan(), random_chan(), random_chan());
            end
            finish_activity();
        end

        wait_drained();
        repeat (16) @(negedge clk);
        if (fail_count == 0 && line_forecast.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #48_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
